FILE: hdl/neighbour_difference_smoother_assert.svh
// ----------------------------------------------------------------------------
// neighbour_difference_smoother_assert.svh
// Assertion macros used by the smoother back end, nds_back.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOUR_DIFFERENCE_SMOOTHER_ASSERT_SVH
`define NEIGHBOUR_DIFFERENCE_SMOOTHER_ASSERT_SVH

// same-cycle implication, off while in reset
`define NDS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("neighbour_difference_smoother: same-cycle check failed");

// next-cycle implication, off while in reset
`define NDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("neighbour_difference_smoother: next-cycle check failed");

`endif

FILE: hdl/nds_pkg.sv
// ----------------------------------------------------------------------------
// nds_pkg
// Shared types and fixed widths of the neighbour-difference smoother.
// ----------------------------------------------------------------------------
package nds_pkg;

    localparam int PIX_W      = 16;
    localparam int UPD_W      = 32;
    localparam int GAIN_W     = 16;
    localparam int FRAC_W     = 16;
    localparam int COORD_W    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [COORD_W-1:0] t_coord;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_SMOOTH,
        CMD_PASS
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic [7:0]               col;
        logic [7:0]               row;
        t_coord                   x0;
        t_coord                   x1;
        t_coord                   y0;
        t_coord                   y1;
        logic [PIX_W-1:0]         pix;
        logic signed [UPD_W-1:0]  upd;
    } t_cmd;

endpackage

FILE: hdl/nds_ram.sv
// ----------------------------------------------------------------------------
// nds_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/nds_fifo.sv
// ----------------------------------------------------------------------------
// nds_fifo
// Short command queue between the classifier and the window engine.
// ----------------------------------------------------------------------------
module nds_fifo
    import nds_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty
);

    localparam int PW = $clog2(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_count;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;

    assign n_wr    = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd    = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
    assign o_full  = (r_count == (PW + 1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hdl/nds_front.sv
// ----------------------------------------------------------------------------
// nds_front
// Configuration registers, item classification and window clipping.
// ----------------------------------------------------------------------------
module nds_front
    import nds_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_RADIUS = 7
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_action,
    input  logic [7:0]              i_column,
    input  logic [7:0]              i_row,
    input  logic [PIX_W-1:0]        i_pixel_value,
    input  logic signed [UPD_W-1:0] i_update_in,
    input  logic                    i_full,
    output logic                    o_push,
    output t_cmd                    o_cmd,
    output logic [GAIN_W-1:0]       o_gain
);

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd3;
    localparam int RAD_W = 4;

    logic [COORD_W-1:0] r_width;
    logic [COORD_W-1:0] r_height;
    logic [2:0]         r_radius;
    logic [GAIN_W-1:0]  r_gain;

    logic [COORD_W-1:0] w_eff;
    logic [COORD_W-1:0] h_eff;
    logic [RAD_W-1:0]   rad;
    logic [9:0]         rad_ext;
    logic [9:0]         col_ext;
    logic [9:0]         row_ext;
    logic [9:0]         x_hi;
    logic [9:0]         y_hi;
    logic [9:0]         x_lim;
    logic [9:0]         y_lim;
    logic               in_store;
    logic               in_image;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 9'd256;
            r_height <= 9'd256;
            r_radius <= 3'd1;
            r_gain   <= 16'd655;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data[COORD_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[COORD_W-1:0];
                CFG_RADIUS: r_radius <= i_cfg_data[2:0];
                CFG_GAIN:   r_gain   <= i_cfg_data[GAIN_W-1:0];
                default:    r_gain   <= r_gain;
            endcase
        end
    end

    assign w_eff = (32'(r_width) > MAX_WIDTH) ? COORD_W'(MAX_WIDTH) : r_width;
    assign h_eff = (32'(r_height) > MAX_HEIGHT) ? COORD_W'(MAX_HEIGHT) : r_height;
    assign rad   = (32'(r_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(r_radius);

    assign rad_ext = 10'(rad);
    assign col_ext = {2'b00, i_column};
    assign row_ext = {2'b00, i_row};
    assign x_hi    = col_ext + rad_ext;
    assign y_hi    = row_ext + rad_ext;
    assign x_lim   = {1'b0, w_eff} - 10'd1;
    assign y_lim   = {1'b0, h_eff} - 10'd1;

    assign in_store = (32'(i_column) < MAX_WIDTH) && (32'(i_row) < MAX_HEIGHT);
    assign in_image = ({1'b0, i_column} < w_eff) && ({1'b0, i_row} < h_eff);

    always_comb begin
        o_cmd.kind = i_action ? (in_image ? CMD_SMOOTH : CMD_PASS) : CMD_LOAD;
        o_cmd.col  = i_column;
        o_cmd.row  = i_row;
        o_cmd.x0   = (col_ext >= rad_ext) ? COORD_W'(col_ext - rad_ext) : '0;
        o_cmd.x1   = (x_hi > x_lim) ? x_lim[COORD_W-1:0] : x_hi[COORD_W-1:0];
        o_cmd.y0   = (row_ext >= rad_ext) ? COORD_W'(row_ext - rad_ext) : '0;
        o_cmd.y1   = (y_hi > y_lim) ? y_lim[COORD_W-1:0] : y_hi[COORD_W-1:0];
        o_cmd.pix  = i_pixel_value;
        o_cmd.upd  = i_update_in;
    end

    // drop loads that fall outside the store
    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full && (i_action || in_store);
    assign o_gain     = r_gain;

endmodule

FILE: hdl/nds_back.sv
// ----------------------------------------------------------------------------
// nds_back
// Frame store, window sweep, gain multiply, rounding and result register.
// ----------------------------------------------------------------------------
`include "neighbour_difference_smoother_assert.svh"

module nds_back
    import nds_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_RADIUS = 7
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_empty,
    input  t_cmd                    i_head,
    output logic                    o_pop,
    input  logic [GAIN_W-1:0]       i_gain,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [UPD_W-1:0] o_update_out
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
    localparam int ACC_W = PIX_W + CNT_W;
    localparam int SUM_W = ACC_W + 1;
    localparam int PRD_W = SUM_W + GAIN_W + 1;
    localparam int RND_W = PRD_W - FRAC_W;
    localparam int TOT_W = ((RND_W > UPD_W) ? RND_W : UPD_W) + 1;
    localparam int ROUND_BIAS = 1 << (FRAC_W - 1);
    localparam logic signed [TOT_W-1:0] SAT_HI =
        {{(TOT_W - UPD_W + 1){1'b0}}, {(UPD_W - 1){1'b1}}};
    localparam logic signed [TOT_W-1:0] SAT_LO =
        {{(TOT_W - UPD_W + 1){1'b1}}, {(UPD_W - 1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_CPROD,
        ST_DIFF,
        ST_MUL,
        ST_FINAL
    } t_state;

    t_state                   r_state;
    t_cmd                     r_cmd;
    logic                     r_pass;
    t_coord                   r_x;
    t_coord                   r_y;
    logic [AW-1:0]            r_base;
    logic                     r_rd_vld;
    logic                     r_rd_centre;
    logic [ACC_W-1:0]         r_acc;
    logic [CNT_W-1:0]         r_cnt;
    logic [PIX_W-1:0]         r_centre;
    logic [ACC_W-1:0]         r_nc;
    logic signed [SUM_W-1:0]  r_diff;
    logic signed [PRD_W-1:0]  r_prod;
    logic                     r_out_valid;
    logic signed [UPD_W-1:0]  r_out_data;

    logic                     ram_wr_en;
    logic [AW-1:0]            ram_wr_addr;
    logic                     ram_rd_en;
    logic [AW-1:0]            ram_rd_addr;
    logic [PIX_W-1:0]         ram_q;
    logic                     out_free;
    logic                     out_load;
    logic signed [GAIN_W:0]   gain_s;
    logic signed [PRD_W-1:0]  n_biased;
    logic signed [TOT_W-1:0]  n_total;
    logic signed [UPD_W-1:0]  n_sat;

    assign o_pop       = (r_state == ST_IDLE) && !i_empty;
    assign ram_wr_en   = o_pop && (i_head.kind == CMD_LOAD);
    assign ram_wr_addr = AW'(32'(i_head.row) * MAX_WIDTH + 32'(i_head.col));
    assign ram_rd_en   = (r_state == ST_SWEEP);
    assign ram_rd_addr = r_base + AW'(r_x);
    assign out_free    = !r_out_valid || i_out_ready;
    assign out_load    = (r_state == ST_FINAL) && out_free;
    assign gain_s      = {1'b0, i_gain};

    assign n_biased = r_prod + $signed(PRD_W'(ROUND_BIAS));
    assign n_total  = TOT_W'($signed(n_biased[PRD_W-1:FRAC_W])) + TOT_W'(r_cmd.upd);
    assign n_sat    = (n_total > SAT_HI) ? SAT_HI[UPD_W-1:0] :
                      (n_total < SAT_LO) ? SAT_LO[UPD_W-1:0] : n_total[UPD_W-1:0];

    nds_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (i_head.pix),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rd_vld    <= 1'b0;
            r_rd_centre <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld    <= (r_state == ST_SWEEP);
            r_rd_centre <= (r_state == ST_SWEEP) && (r_x == {1'b0, r_cmd.col})
                           && (r_y == {1'b0, r_cmd.row});
            if (r_rd_vld) begin
                r_acc <= r_acc + ACC_W'(ram_q);
                r_cnt <= r_cnt + 1'b1;
                if (r_rd_centre) begin
                    r_centre <= ram_q;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_cmd  <= i_head;
                        r_pass <= (i_head.kind == CMD_PASS);
                        r_x    <= i_head.x0;
                        r_y    <= i_head.y0;
                        r_base <= AW'(32'(i_head.y0) * MAX_WIDTH);
                        r_acc  <= '0;
                        r_cnt  <= '0;
                        case (i_head.kind)
                            CMD_SMOOTH: r_state <= ST_SWEEP;
                            CMD_PASS:   r_state <= ST_FINAL;
                            default:    r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_SWEEP: begin
                    if (r_x == r_cmd.x1) begin
                        r_x    <= r_cmd.x0;
                        r_y    <= r_y + 1'b1;
                        r_base <= r_base + AW'(MAX_WIDTH);
                        if (r_y == r_cmd.y1) begin
                            r_state <= ST_DRAIN;
                        end
                    end else begin
                        r_x <= r_x + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_CPROD;
                end
                ST_CPROD: begin
                    r_nc    <= ACC_W'(r_cnt) * ACC_W'(r_centre);
                    r_state <= ST_DIFF;
                end
                ST_DIFF: begin
                    r_diff  <= $signed({1'b0, r_acc}) - $signed({1'b0, r_nc});
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_prod  <= PRD_W'(r_diff) * PRD_W'(gain_s);
                    r_state <= ST_FINAL;
                end
                ST_FINAL: begin
                    if (out_free) begin
                        r_out_data  <= r_pass ? r_cmd.upd : n_sat;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_update_out = r_out_data;

    `NDS_ASSERT_IMPLY(a_window_nonempty, i_clk, i_rst_n, r_state == ST_CPROD, r_cnt != '0)
    `NDS_ASSERT_IMPLY(a_no_write_in_flight, i_clk, i_rst_n, ram_wr_en, !r_rd_vld)
    `NDS_ASSERT_NEXT(a_final_delivers, i_clk, i_rst_n, out_load, r_out_valid && (r_state == ST_IDLE))
    `NDS_ASSERT_IMPLY(a_drain_after_last_row, i_clk, i_rst_n, r_state == ST_DRAIN, r_y == t_coord'(r_cmd.y1 + 1'b1))

endmodule

FILE: hdl/neighbour_difference_smoother.sv
// ----------------------------------------------------------------------------
// neighbour_difference_smoother
// Box-window neighbour-difference smoothing over one stored image plane.
//
//   channel  direction  handshake                   payload
//   in       sink       i_in_valid / o_in_ready     action, column, row,
//                                                   pixel_value, update_in
//   out      source     o_out_valid / i_out_ready   update_out
//   cfg      sink       i_cfg_valid / o_cfg_ready   cfg_index, cfg_data
//
// A smooth item inside the image has the window engine sweep the single
// frame store read port once per pixel of its clipped window, a window of
// 9 pixels at radius 1.
// Loads are written on pop; smooths outside the image skip the sweep.
// A four-entry queue lets the input side run ahead of the window engine.
// Reset is synchronous; it clears control state only, not the frame store.
// ----------------------------------------------------------------------------
module neighbour_difference_smoother
    import nds_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_RADIUS = 7
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_action,
    input  logic [7:0]              i_column,
    input  logic [7:0]              i_row,
    input  logic [PIX_W-1:0]        i_pixel_value,
    input  logic signed [UPD_W-1:0] i_update_in,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [UPD_W-1:0] o_update_out
);

    t_cmd              cmd_push;
    t_cmd              cmd_head;
    logic              push;
    logic              pop;
    logic              full;
    logic              empty;
    logic [GAIN_W-1:0] gain;

    assign o_cfg_ready = 1'b1;

    nds_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_column      (i_column),
        .i_row         (i_row),
        .i_pixel_value (i_pixel_value),
        .i_update_in   (i_update_in),
        .i_full        (full),
        .o_push        (push),
        .o_cmd         (cmd_push),
        .o_gain        (gain)
    );

    nds_fifo #(
        .DEPTH (4)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_push),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (cmd_head),
        .o_empty (empty)
    );

    nds_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_head       (cmd_head),
        .o_pop        (pop),
        .i_gain       (gain),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_update_out (o_update_out)
    );

endmodule

FILE: bench/nds_tb_pkg.sv
// ----------------------------------------------------------------------------
// nds_tb_pkg
// Register indexes, action codes and store geometry shared by the smoother
// bench files.
// ----------------------------------------------------------------------------
package nds_tb_pkg;

    typedef enum logic [1:0] {
        REG_WIDTH,
        REG_HEIGHT,
        REG_RADIUS,
        REG_GAIN
    } t_reg;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SMOOTH = 1'b1;

    localparam int STORE_W    = 256;
    localparam int STORE_H    = 256;
    localparam int RADIUS_CAP = 7;

endpackage

FILE: bench/nds_checker.sv
// ----------------------------------------------------------------------------
// nds_checker
// Watches the configuration, input and output channels of the smoother,
// keeps its own copy of the frame store and the registers, works out the
// smoothed update for every accepted smooth beat and compares it with the
// result beats in order. Hands the mismatch count and the number of
// outstanding results to the bench top.
// ----------------------------------------------------------------------------
module nds_checker
    import nds_pkg::*;
    import nds_tb_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic                    i_action,
    input  logic [7:0]              i_column,
    input  logic [7:0]              i_row,
    input  logic [PIX_W-1:0]        i_pixel_value,
    input  logic signed [UPD_W-1:0] i_update_in,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic signed [UPD_W-1:0] i_update_out,
    output int                      o_mismatches,
    output int                      o_pending
);

    logic [PIX_W-1:0]        pixel_store [STORE_W*STORE_H];
    logic [8:0]              width_reg;
    logic [8:0]              height_reg;
    logic [2:0]              radius_reg;
    logic [GAIN_W-1:0]       gain_reg;
    logic signed [UPD_W-1:0] pending_updates [$];
    logic signed [UPD_W-1:0] want;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        for (int a = 0; a < STORE_W*STORE_H; a++) begin
            pixel_store[a] = '0;
        end
    end

    function automatic logic signed [UPD_W-1:0] smoothed_update(
        input int col,
        input int row,
        input logic signed [UPD_W-1:0] upd
    );
        int     w;
        int     h;
        int     r;
        int     x0;
        int     x1;
        int     y0;
        int     y1;
        longint centre;
        longint sum;
        longint total;
        w = (width_reg > STORE_W) ? STORE_W : int'(width_reg);
        h = (height_reg > STORE_H) ? STORE_H : int'(height_reg);
        r = (radius_reg > RADIUS_CAP) ? RADIUS_CAP : int'(radius_reg);
        if (col >= w || row >= h) begin
            return upd;
        end
        x0 = (col - r < 0) ? 0 : col - r;
        x1 = (col + r > w - 1) ? w - 1 : col + r;
        y0 = (row - r < 0) ? 0 : row - r;
        y1 = (row + r > h - 1) ? h - 1 : row + r;
        centre = longint'(pixel_store[row*STORE_W + col]);
        sum = 0;
        for (int y = y0; y <= y1; y++) begin
            for (int x = x0; x <= x1; x++) begin
                sum += longint'(pixel_store[y*STORE_W + x]) - centre;
            end
        end
        // round sum*gain (Q0.16) half up to integer: add half an lsb, floor
        total = longint'(upd) + ((sum * longint'(gain_reg) + 64'sd32768) >>> FRAC_W);
        if (total > 64'sd2147483647) begin
            total = 64'sd2147483647;
        end
        if (total < -64'sd2147483648) begin
            total = -64'sd2147483648;
        end
        return total[UPD_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("nds_checker: %s", what);
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = 9'd256;
            height_reg = 9'd256;
            radius_reg = 3'd1;
            gain_reg   = 16'd655;
            pending_updates.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_WIDTH: begin
                        width_reg = i_cfg_data[8:0];
                    end
                    REG_HEIGHT: begin
                        height_reg = i_cfg_data[8:0];
                    end
                    REG_RADIUS: begin
                        radius_reg = i_cfg_data[2:0];
                    end
                    REG_GAIN: begin
                        gain_reg = i_cfg_data[GAIN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_action == ACT_LOAD) begin
                    pixel_store[int'(i_row)*STORE_W + int'(i_column)] = i_pixel_value;
                end else begin
                    pending_updates.push_back(
                        smoothed_update(int'(i_column), int'(i_row), i_update_in));
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_updates.size() == 0) begin
                    report_mismatch($sformatf("result beat %0d with none outstanding",
                                              i_update_out));
                end else begin
                    want = pending_updates.pop_front();
                    if (i_update_out !== want) begin
                        report_mismatch($sformatf("update_out %0d, expected %0d",
                                                  i_update_out, want));
                    end
                end
            end
        end
        o_pending = pending_updates.size();
    end

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Bench for neighbour_difference_smoother. Drives directed corner cases and
// then random load and smooth beats over a series of image sizes, radii and
// gains, with random gaps on both channels, one long output stall and a
// drain before every reconfiguration. Checking is done by nds_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import nds_pkg::*;
    import nds_tb_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 32;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic                    action;
    logic [7:0]              column;
    logic [7:0]              row;
    logic [PIX_W-1:0]        pixel_value;
    logic signed [UPD_W-1:0] update_in;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [UPD_W-1:0] update_out;

    int mismatches;
    int pending;
    int stall_cycles;
    int img_w;
    int img_h;
    int img_r;
    bit send_calm;
    bit recv_calm;
    bit hold_results;
    bit loaded [STORE_W*STORE_H];

    neighbour_difference_smoother DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_action      (action),
        .i_column      (column),
        .i_row         (row),
        .i_pixel_value (pixel_value),
        .i_update_in   (update_in),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_update_out  (update_out)
    );

    nds_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_action      (action),
        .i_column      (column),
        .i_row         (row),
        .i_pixel_value (pixel_value),
        .i_update_in   (update_in),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_update_out  (update_out),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    initial begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic int draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [UPD_W-1:0] rand_update();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed($urandom_range(0, 131071)) - 65536;
            default: return $urandom;
        endcase
    endfunction

    // small images: anywhere; large ones: a 16-wide band at either end
    function automatic int pick_coord(input int extent);
        if (extent <= 16) begin
            return $urandom_range(0, extent - 1);
        end
        return ($urandom_range(0, 1) ? extent - 16 : 0) + $urandom_range(0, 15);
    endfunction

    // output side: random gaps, calm stretches, one long hold on request
    initial begin
        int gap;
        out_ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever begin
            if (hold_results) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_results = 1'b0;
            end
            if ($urandom_range(0, 39) == 0) begin
                recv_calm = !recv_calm;
            end
            gap = draw_gap(recv_calm);
            if (gap != 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            @(negedge clk);
        end
    end

    task automatic send_beat(
        input logic                    act,
        input int                      c,
        input int                      r,
        input logic [PIX_W-1:0]        p,
        input logic signed [UPD_W-1:0] u
    );
        int gap;
        if ($urandom_range(0, 39) == 0) begin
            send_calm = !send_calm;
        end
        gap = draw_gap(send_calm);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        column      <= c[7:0];
        row         <= r[7:0];
        pixel_value <= p;
        update_in   <= u;
        do @(posedge clk); while (!(in_valid && in_ready));
        @(negedge clk);
    endtask

    task automatic load_pixel(input int c, input int r, input logic [PIX_W-1:0] p);
        send_beat(ACT_LOAD, c, r, p, $urandom);
        loaded[r*STORE_W + c] = 1'b1;
    endtask

    // write any unloaded pixel of the clipped window first
    task automatic smooth_pixel(input int c, input int r, input logic signed [UPD_W-1:0] u);
        if (c < img_w && r < img_h) begin
            for (int y = (r - img_r < 0 ? 0 : r - img_r);
                 y <= (r + img_r > img_h - 1 ? img_h - 1 : r + img_r); y++) begin
                for (int x = (c - img_r < 0 ? 0 : c - img_r);
                     x <= (c + img_r > img_w - 1 ? img_w - 1 : c + img_r); x++) begin
                    if (!loaded[y*STORE_W + x]) begin
                        load_pixel(x, y, rand_pixel());
                    end
                end
            end
        end
        send_beat(ACT_SMOOTH, c, r, PIX_W'($urandom), u);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input t_reg idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        @(negedge clk);
    endtask

    task automatic configure(input int w, input int h, input int r, input int g);
        drain();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_RADIUS, r);
        write_reg(REG_GAIN, g);
        cfg_valid <= 1'b0;
        img_w = (w > STORE_W) ? STORE_W : w;
        img_h = (h > STORE_H) ? STORE_H : h;
        img_r = r;
    endtask

    task automatic fill_image();
        for (int y = 0; y < img_h; y++) begin
            for (int x = 0; x < img_w; x++) begin
                load_pixel(x, y, rand_pixel());
            end
        end
    endtask

    task automatic run_random(input int beats);
        int  pick;
        bit  inside_ok;
        repeat (beats) begin
            pick      = $urandom_range(0, 99);
            inside_ok = (img_w > 0 && img_h > 0);
            if (pick < 25 && inside_ok) begin
                load_pixel(pick_coord(img_w), pick_coord(img_h), rand_pixel());
            end else if (pick < 32) begin
                load_pixel($urandom_range(0, 255), $urandom_range(0, 255), rand_pixel());
            end else if ((pick < 42 || !inside_ok) && img_w < STORE_W) begin
                smooth_pixel($urandom_range(img_w, 255), $urandom_range(0, 255),
                             rand_update());
            end else if ((pick < 42 || !inside_ok) && img_h < STORE_H) begin
                smooth_pixel($urandom_range(0, 255), $urandom_range(img_h, 255),
                             rand_update());
            end else begin
                smooth_pixel(pick_coord(img_w), pick_coord(img_h), rand_update());
            end
        end
    endtask

    initial begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        action       = ACT_LOAD;
        column       = '0;
        row          = '0;
        pixel_value  = '0;
        update_in    = '0;
        stall_cycles = 0;
        send_calm    = 1'b0;
        recv_calm    = 1'b0;
        hold_results = 1'b0;
        img_w        = STORE_W;
        img_h        = STORE_H;
        img_r        = 1;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // corners at reset settings: saturation both ways, clipped windows
        load_pixel(0, 0, 16'h0000);
        load_pixel(1, 0, 16'hFFFF);
        load_pixel(0, 1, 16'hFFFF);
        load_pixel(1, 1, 16'hFFFF);
        smooth_pixel(0, 0, 32'sh7FFF_FFFF);
        smooth_pixel(0, 0, 32'sh0000_0000);
        load_pixel(255, 255, 16'hFFFF);
        load_pixel(254, 255, 16'h0000);
        load_pixel(255, 254, 16'h0000);
        load_pixel(254, 254, 16'h0000);
        smooth_pixel(255, 255, 32'sh8000_0000);
        smooth_pixel(255, 255, -32'sd1);
        smooth_pixel(254, 254, 32'sd12345);

        configure(8, 8, 1, 655);
        fill_image();
        run_random(100);

        configure(1, 1, 7, 65535);
        fill_image();
        run_random(40);

        // long output hold while beats keep coming
        configure(16, 5, 7, 65535);
        fill_image();
        hold_results = 1'b1;
        run_random(120);

        configure(256, 256, 0, 1234);
        run_random(100);

        // oversized sizes clamp; zero gain passes the update through
        configure(300, 511, 1, 0);
        run_random(60);

        // empty image: every smooth passes straight through
        configure(0, 10, 3, 777);
        run_random(40);

        repeat (4) begin
            configure($urandom_range(1, 16), $urandom_range(1, 16),
                      $urandom_range(0, 7), $urandom_range(0, 65535));
            fill_image();
            run_random(70);
        end

        drain();
        if (mismatches == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/nds_pkg.sv
hdl/nds_ram.sv
hdl/nds_fifo.sv
hdl/nds_front.sv
hdl/nds_back.sv
hdl/neighbour_difference_smoother.sv
bench/nds_tb_pkg.sv
bench/nds_checker.sv
bench/tb_top.sv
